// File: design/pihbf_pkg.sv
// Package for the PI heater regulator with burst-fire output.
// Holds field widths, register indexes, reset values and shared structs.
// No dependencies.
`default_nettype none

package pihbf_pkg;

   localparam int TEMP_W   = 12;
   localparam int GAIN_W   = 16;
   localparam int DRIVE_W  = 10;
   localparam int LIMIT_W  = 6;
   localparam int ERR_W    = TEMP_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_A      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_B      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MAX   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_LIMIT = 3'd4;

   localparam logic [TEMP_W-1:0]  SETPOINT_RST    = 12'd560;
   localparam logic [GAIN_W-1:0]  GAIN_A_RST      = 16'd4551;
   localparam logic [GAIN_W-1:0]  GAIN_B_RST      = 16'd4110;
   localparam logic [DRIVE_W-1:0] DRIVE_MAX_RST   = 10'd960;
   localparam logic [LIMIT_W-1:0] CYCLE_LIMIT_RST = 6'd60;

   localparam logic ACTION_SAMPLE   = 1'b0;
   localparam logic ACTION_CROSSING = 1'b1;

   typedef struct packed {
      logic [TEMP_W-1:0]  setpoint;
      logic [GAIN_W-1:0]  gain_a;
      logic [GAIN_W-1:0]  gain_b;
      logic [DRIVE_W-1:0] drive_max;
      logic [LIMIT_W-1:0] cycle_limit;
   } cfg_type;

   typedef struct packed {
      logic              action;
      logic [TEMP_W-1:0] temperature;
   } item_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive_value;
      logic               heater_on;
      logic               event_kind;
   } result_type;

endpackage

`default_nettype wire

// File: design/pi_heater_burst_fire.sv
// Top level of the PI heater regulator with burst-fire output.
// Instantiates pihbf_csr and pihbf_core; depends on pihbf_pkg.
//
//   channel  | direction | handshake           | beat contents
//   ---------+-----------+---------------------+-------------------------------
//   req_     | in        | req_valid/req_stall | action, temperature
//   rsp_     | out       | rsp_valid/rsp_stall | drive_value, heater_on, event_kind
//   csr_     | in        | csr_valid/csr_ready | index (0..4), data
//
// One beat per cycle sustained while rsp_stall stays low; a request beat lands
// in the input register, passes the combinational PI/burst logic and then
// lands in the result register, which drives rsp_valid and the result beat.
// Synchronous reset clears the controller state, both valid flags and loads
// the register defaults. While the result register is held by rsp_stall,
// the input register holds too and req_stall rises once it is occupied.
`default_nettype none

module pi_heater_burst_fire
   import pihbf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_action,
   input  wire logic [TEMP_W-1:0]     req_temperature,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [DRIVE_W-1:0]         rsp_drive_value,
   output logic                       rsp_heater_on,
   output logic                       rsp_event_kind,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   result_type result, rsp_ff;
   logic       in_valid_ff, in_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_take;

   pihbf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Move the input beat into the result register when that slot is free
   // or drains this cycle; state in the core updates on the same edge.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   pihbf_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item_ff),
      .advance (advance),
      .result  (result)
   );

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         item_in.action      = req_action;
         item_in.temperature = req_temperature;
         in_valid_in         = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;  // drop the beat once taken
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: hold while stalled, no reset needed
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = rsp_ff.drive_value;
   assign rsp_heater_on   = rsp_ff.heater_on;
   assign rsp_event_kind  = rsp_ff.event_kind;

endmodule

`default_nettype wire

// File: design/pihbf_csr.sv
// Configuration register file of the heater regulator.
// Depends on pihbf_pkg for register indexes, widths and reset values.
`default_nettype none

module pihbf_csr
   import pihbf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SETPOINT:    cfg_in.setpoint    = csr_data[TEMP_W-1:0];
            CSR_GAIN_A:      cfg_in.gain_a      = csr_data[GAIN_W-1:0];
            CSR_GAIN_B:      cfg_in.gain_b      = csr_data[GAIN_W-1:0];
            CSR_DRIVE_MAX:   cfg_in.drive_max   = csr_data[DRIVE_W-1:0];
            CSR_CYCLE_LIMIT: cfg_in.cycle_limit = csr_data[LIMIT_W-1:0];
            default:         cfg_in = cfg_ff;  // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint    <= SETPOINT_RST;
         cfg_ff.gain_a      <= GAIN_A_RST;
         cfg_ff.gain_b      <= GAIN_B_RST;
         cfg_ff.drive_max   <= DRIVE_MAX_RST;
         cfg_ff.cycle_limit <= CYCLE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: design/pihbf_core.sv
// Controller datapath and state: PI drive update and burst-fire decision.
// Depends on pihbf_pkg for widths, action codes and structs.
`default_nettype none

module pihbf_core
   import pihbf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire item_type item,
   input  wire logic     advance,
   output result_type    result
);

   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;
   logic [DRIVE_W-1:0]      drive_ff, drive_in;
   logic [LIMIT_W-1:0]      count_ff, count_in;
   logic                    heater_ff, heater_in;

   logic signed [ERR_W-1:0]            err;
   logic signed [GAIN_W+ERR_W:0]       prod_a, prod_b;
   logic signed [GAIN_W+ERR_W-12:0]    term_a, term_b;
   logic signed [GAIN_W+ERR_W-10:0]    sum;
   logic [DRIVE_W-1:0]                 drive_sat;
   logic [LIMIT_W:0]                   count_inc;
   logic                               fire;

   assign err = $signed({cfg.setpoint[TEMP_W-1], cfg.setpoint})
              - $signed({item.temperature[TEMP_W-1], item.temperature});

   // Gains are unsigned: prepend a zero so the products stay signed.
   assign prod_a = $signed({1'b0, cfg.gain_a}) * err;
   assign prod_b = $signed({1'b0, cfg.gain_b}) * prev_err_ff;

   // Arithmetic shift right 12: keep the upper bits, floor toward minus infinity.
   assign term_a = prod_a[GAIN_W+ERR_W:12];
   assign term_b = prod_b[GAIN_W+ERR_W:12];

   assign sum = $signed({{(GAIN_W+ERR_W-9-DRIVE_W){1'b0}}, drive_ff})
              + $signed({{2{term_a[GAIN_W+ERR_W-12]}}, term_a})
              - $signed({{2{term_b[GAIN_W+ERR_W-12]}}, term_b});

   always_comb begin
      if (sum < 0) begin
         drive_sat = '0;
      end else if (sum > $signed({{(GAIN_W+ERR_W-9-DRIVE_W){1'b0}}, cfg.drive_max})) begin
         drive_sat = cfg.drive_max;
      end else begin
         drive_sat = sum[DRIVE_W-1:0];
      end
   end

   assign count_inc = {1'b0, count_ff} + {{LIMIT_W{1'b0}}, 1'b1};
   assign fire      = {1'b0, drive_ff} > {count_inc, 4'b0000};

   always_comb begin
      prev_err_in = prev_err_ff;
      drive_in    = drive_ff;
      count_in    = count_ff;
      heater_in   = heater_ff;
      if (item.action == ACTION_SAMPLE) begin
         prev_err_in = err;
         drive_in    = drive_sat;
      end else begin
         heater_in = fire;
         // clear once past the limit; a count of 64 always clears
         if (count_inc > {1'b0, cfg.cycle_limit}) begin
            count_in = '0;
         end else begin
            count_in = count_inc[LIMIT_W-1:0];
         end
      end
   end

   assign result.drive_value = drive_in;
   assign result.heater_on   = heater_in;
   assign result.event_kind  = item.action;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         drive_ff    <= '0;
         count_ff    <= '0;
         heater_ff   <= 1'b0;
      end else if (advance) begin
         prev_err_ff <= prev_err_in;
         drive_ff    <= drive_in;
         count_ff    <= count_in;
         heater_ff   <= heater_in;
      end
   end

endmodule

`default_nettype wire
